### rtl/frequency_rank_unary_coder_core_defines.svh
// Assertion macros for the coder core; clocked on clk, held off during rst.
`ifndef FREQUENCY_RANK_UNARY_CODER_CORE_DEFINES_SVH
`define FREQUENCY_RANK_UNARY_CODER_CORE_DEFINES_SVH

`define FRQR_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define FRQR_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/frqr_pkg.sv
`default_nettype none
package frqr_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] symbol;
  } req_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic [7:0] rank;
    logic [7:0] code_length;
    logic       ends_in_zero;
    logic       last;
    logic       none_left;
    logic       overflowed;
  } res_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_WALK,
    S_READOUT,
    S_EMIT_BS,
    S_EMIT_RT,
    S_EMIT_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/frequency_rank_unary_coder_core.sv
// Frequency-ranked unary coder.
// req channel (req_valid/req_stall/req): cmd load stores one byte and counts it;
// cmd emit asks for the code of the next stored byte in load order.
// res channel (res_valid/res_stall/res): one item per emit, none per load.
// Items are taken one at a time; req_stall is high while an item is in work.
// A load reads the histogram when taken and writes it back in S_LOAD_WR
// (read-modify-write); a dropped load goes straight back to idle. An emit
// passes the byte store read, the rank table read and the output register
// before res_valid. The first emit of a block also ranks it: a walk of the
// histogram memory feeds a chain of ALPHABET sorting cells, which is then
// shifted into the rank table, one distinct value per cycle.
// Emit with nothing pending goes straight to the output register with none_left.
// A stalled result holds in the output register; the next item is not taken
// until it has been moved into that register.
// rst (synchronous) empties the block; the block also empties after its last
// code is given.
`default_nettype none
`include "frequency_rank_unary_coder_core_defines.svh"
module frequency_rank_unary_coder_core import frqr_pkg::*; #(
  parameter int BLOCK_LEN = 256,
  parameter int ALPHABET  = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int AW = $clog2(ALPHABET);
  localparam int CW = $clog2(BLOCK_LEN + 1);
  localparam int BW = $clog2(BLOCK_LEN);
  localparam int KW = $clog2(ALPHABET + 1);

  state_t            state, state_next;
  logic [CW-1:0]     loaded_count, emit_pointer;
  logic [KW-1:0]     distinct;
  logic              ranks_ready, overflow_flag;
  logic [ALPHABET-1:0] hvalid;
  logic [AW-1:0]     ld_sym, walk_addr, pend_sym, rd_rank;
  logic              walk_issued, pend, none_pend;
  logic [7:0]        em_sym;

  logic              accept, load_ok, pending, out_free, last_c;
  chain_ctrl_t       ctrl;
  logic [CW-1:0]     hist_rdata, hist_wdata;
  logic [AW-1:0]     hist_raddr, rt_raddr, rt_rdata;
  logic [7:0]        bs_rdata;
  res_t              built;
  logic [8:0]        k9, r9;

  logic [ALPHABET-1:0] cv, cv_inc, cgt;
  logic [CW-1:0]     ccnt [ALPHABET];
  logic [AW-1:0]     cval [ALPHABET];

  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign load_ok   = !ranks_ready && (loaded_count < CW'(BLOCK_LEN))
                     && ({1'b0, req.symbol} < 9'(ALPHABET));
  assign pending   = emit_pointer < loaded_count;
  assign out_free  = !res_valid || !res_stall;
  assign last_c    = (emit_pointer + CW'(1)) == loaded_count;
  assign ctrl.insert    = (state == S_WALK) && pend && hvalid[pend_sym];
  assign ctrl.shift_out = (state == S_READOUT);
  assign hist_raddr = (state == S_WALK) ? walk_addr : req.symbol[AW-1:0];
  assign hist_wdata = (hvalid[ld_sym] ? hist_rdata : '0) + CW'(1);
  assign rt_raddr   = (state == S_EMIT_RT) ? bs_rdata[AW-1:0] : em_sym[AW-1:0];
  assign cv_inc     = cv + {{(ALPHABET-1){1'b0}}, 1'b1};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_LOAD) begin
            state_next = load_ok ? S_LOAD_WR : S_IDLE;
          end else if (!pending) begin
            state_next = S_EMIT_OUT;
          end else if (!ranks_ready) begin
            state_next = S_WALK;
          end else begin
            state_next = S_EMIT_BS;
          end
        end
      end
      S_LOAD_WR:  state_next = S_IDLE;
      S_WALK:     if (walk_issued && !pend) state_next = S_READOUT;
      S_READOUT:  if (!cv[0]) state_next = S_EMIT_BS;
      S_EMIT_BS:  state_next = S_EMIT_RT;
      S_EMIT_RT:  state_next = S_EMIT_OUT;
      S_EMIT_OUT: if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    k9    = 9'(distinct);
    r9    = 9'(rt_raddr == rt_raddr ? rt_rdata : rt_rdata);
    built = '0;
    built.overflowed = overflow_flag;
    if (none_pend) begin
      built.none_left = 1'b1;
    end else begin
      built.out_symbol = em_sym;
      built.rank       = 8'(rt_rdata);
      built.last       = last_c;
      if (k9 > 9'd1) begin
        if (r9 + 9'd1 == k9) begin
          built.code_length = 8'(k9 - 9'd1);
        end else begin
          built.code_length  = 8'(r9 + 9'd1);
          built.ends_in_zero = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loaded_count  <= '0;
      emit_pointer  <= '0;
      distinct      <= '0;
      ranks_ready   <= 1'b0;
      overflow_flag <= 1'b0;
      hvalid        <= '0;
      walk_issued   <= 1'b0;
      pend          <= 1'b0;
      none_pend     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_WALK) && !walk_issued;
      if (accept && (req.cmd == CMD_LOAD)) begin
        if (load_ok) begin
          loaded_count <= loaded_count + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (accept && (req.cmd == CMD_EMIT)) begin
        none_pend   <= !pending;
        walk_issued <= 1'b0;
      end
      if (state == S_LOAD_WR) begin
        hvalid[ld_sym] <= 1'b1;
      end
      if ((state == S_WALK) && !walk_issued && (walk_addr == AW'(ALPHABET - 1))) begin
        walk_issued <= 1'b1;
      end
      if (ctrl.insert) begin
        distinct <= distinct + KW'(1);
      end
      if ((state == S_READOUT) && !cv[0]) begin
        ranks_ready <= 1'b1;
      end
      if (res_valid && !res_stall && !((state == S_EMIT_OUT) && out_free)) begin
        res_valid <= 1'b0;
      end
      if ((state == S_EMIT_OUT) && out_free) begin
        res_valid <= 1'b1;
        if (!none_pend) begin
          if (last_c) begin
            loaded_count  <= '0;
            emit_pointer  <= '0;
            distinct      <= '0;
            ranks_ready   <= 1'b0;
            overflow_flag <= 1'b0;
            hvalid        <= '0;
          end else begin
            emit_pointer <= emit_pointer + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_sym    <= req.symbol[AW-1:0];
      walk_addr <= '0;
      rd_rank   <= '0;
    end
    if ((state == S_WALK) && !walk_issued) begin
      walk_addr <= walk_addr + AW'(1);
    end
    pend_sym <= walk_addr;
    if ((state == S_READOUT) && cv[0]) begin
      rd_rank <= rd_rank + AW'(1);
    end
    if (state == S_EMIT_RT) begin
      em_sym <= bs_rdata;
    end
    if ((state == S_EMIT_OUT) && out_free) begin
      res <= built;
    end
  end

  frqr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_hist (
    .clk   (clk),
    .we    (state == S_LOAD_WR),
    .waddr (ld_sym),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  frqr_ram #(.WIDTH(8), .DEPTH(BLOCK_LEN)) u_store (
    .clk   (clk),
    .we    (accept && (req.cmd == CMD_LOAD) && load_ok),
    .waddr (loaded_count[BW-1:0]),
    .wdata (req.symbol),
    .raddr (emit_pointer[BW-1:0]),
    .rdata (bs_rdata)
  );

  frqr_ram #(.WIDTH(AW), .DEPTH(ALPHABET)) u_rank (
    .clk   (clk),
    .we    ((state == S_READOUT) && cv[0]),
    .waddr (cval[0]),
    .wdata (rd_rank),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
    logic          p_gt, p_valid, n_valid;
    logic [CW-1:0] p_cnt, n_cnt;
    logic [AW-1:0] p_val, n_val;
    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_cnt   = '0;
      assign p_val   = '0;
    end else begin : g_body
      assign p_gt    = cgt[i-1];
      assign p_valid = cv[i-1];
      assign p_cnt   = ccnt[i-1];
      assign p_val   = cval[i-1];
    end
    if (i == ALPHABET - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_cnt   = '0;
      assign n_val   = '0;
    end else begin : g_link
      assign n_valid = cv[i+1];
      assign n_cnt   = ccnt[i+1];
      assign n_val   = cval[i+1];
    end
    frqr_cell #(.CW(CW), .AW(AW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_cnt    (hist_rdata),
      .new_val    (pend_sym),
      .prev_gt    (p_gt),
      .prev_valid (p_valid),
      .prev_cnt   (p_cnt),
      .prev_val   (p_val),
      .next_valid (n_valid),
      .next_cnt   (n_cnt),
      .next_val   (n_val),
      .valid      (cv[i]),
      .cnt        (ccnt[i]),
      .val        (cval[i]),
      .gt         (cgt[i])
    );
  end

  `FRQR_ALWAYS(a_chain_packed, (cv_inc & cv) == '0, "sort chain has a gap")
  `FRQR_ALWAYS(a_load_bound, loaded_count <= CW'(BLOCK_LEN), "block count past capacity")
  `FRQR_ALWAYS(a_emit_bound, emit_pointer <= loaded_count, "emit pointer past block")
  `FRQR_IMPLIES(a_ranked, ranks_ready, distinct != '0, "ranked block with no values")
  `FRQR_IMPLIES(a_walk_empty, (state == S_WALK) && !walk_issued && (walk_addr == '0), cv == '0, "chain not empty at walk start")

endmodule
`default_nettype wire

### rtl/frqr_ram.sv
`default_nettype none
module frqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/frqr_cell.sv
`default_nettype none
module frqr_cell import frqr_pkg::*; #(
  parameter int CW = 9,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_ctrl_t   ctrl,
  input  logic [CW-1:0] new_cnt,
  input  logic [AW-1:0] new_val,
  input  logic          prev_gt,
  input  logic          prev_valid,
  input  logic [CW-1:0] prev_cnt,
  input  logic [AW-1:0] prev_val,
  input  logic          next_valid,
  input  logic [CW-1:0] next_cnt,
  input  logic [AW-1:0] next_val,
  output logic          valid,
  output logic [CW-1:0] cnt,
  output logic [AW-1:0] val,
  output logic          gt
);

  // strict compare: equal counts stay ahead of a later, higher value
  assign gt = ctrl.insert && (!valid || (new_cnt > cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (prev_gt) begin
        valid <= prev_valid;
      end else if (gt) begin
        valid <= 1'b1;
      end
    end else if (ctrl.shift_out) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (prev_gt) begin
        cnt <= prev_cnt;
        val <= prev_val;
      end else if (gt) begin
        cnt <= new_cnt;
        val <= new_val;
      end
    end else if (ctrl.shift_out) begin
      cnt <= next_cnt;
      val <= next_val;
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import frqr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  frequency_rank_unary_coder_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  localparam int BLK = 256;

  // predictor state
  logic [7:0] blk_bytes [BLK];
  int         sym_count [256];
  logic [7:0] sym_rank [256];
  int         n_loaded, n_emitted, n_distinct;
  bit         ranked, dropped;

  req_t pending_items[$];
  res_t expected_codes[$];
  int   errors = 0;
  bit   stim_done = 1'b0;

  function automatic void clear_block();
    foreach (sym_count[i]) sym_count[i] = 0;
    n_loaded = 0; n_emitted = 0; n_distinct = 0;
    ranked = 1'b0; dropped = 1'b0;
  endfunction

  function automatic void rank_symbols();
    int r;
    n_distinct = 0;
    for (int v = 0; v < 256; v++) begin
      if (sym_count[v] == 0) continue;
      n_distinct++;
      r = 0;
      for (int w = 0; w < 256; w++)
        if (sym_count[w] > sym_count[v] || (sym_count[w] == sym_count[v] && w < v)) r++;
      sym_rank[v] = r[7:0];
    end
    ranked = 1'b1;
  endfunction

  function automatic void predict_code(req_t it);
    res_t e;
    int r;
    e = '0;
    if (it.cmd == CMD_LOAD) begin
      if (ranked || n_loaded >= BLK) dropped = 1'b1;
      else begin
        blk_bytes[n_loaded] = it.symbol;
        sym_count[it.symbol]++;
        n_loaded++;
      end
      return;
    end
    if (n_emitted >= n_loaded) begin
      e.none_left = 1'b1;
      e.overflowed = dropped;
      expected_codes.push_back(e);
      return;
    end
    if (!ranked) rank_symbols();
    e.out_symbol = blk_bytes[n_emitted];
    r = sym_rank[e.out_symbol];
    e.rank = r[7:0];
    if (n_distinct > 1) begin
      if (r + 1 == n_distinct) e.code_length = 8'(n_distinct - 1);
      else begin
        e.code_length = 8'(r + 1);
        e.ends_in_zero = 1'b1;
      end
    end
    e.last = (n_emitted + 1 == n_loaded);
    e.overflowed = dropped;
    expected_codes.push_back(e);
    n_emitted++;
    if (e.last) clear_block();
  endfunction

  function automatic req_t mk(logic c, logic [7:0] s);
    req_t t;
    t.cmd = c; t.symbol = s;
    return t;
  endfunction

  // load a block then emit all of it, occasionally with noise
  task automatic add_block(int len, int span, bit noisy);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++)
      pending_items.push_back(mk(CMD_LOAD, span >= 256 ? 8'($urandom) :
                                 8'(base + $urandom_range(0, span - 1))));
    if (noisy && $urandom_range(0, 1))
      pending_items.push_back(mk(CMD_EMIT, 8'($urandom)));
    if (noisy) pending_items.push_back(mk(CMD_LOAD, 8'($urandom)));
    for (int i = 0; i < len - 1; i++)
      pending_items.push_back(mk(CMD_EMIT, 8'($urandom)));
    if (noisy) pending_items.push_back(mk(CMD_LOAD, 8'($urandom)));
    pending_items.push_back(mk(CMD_EMIT, 8'($urandom)));
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    clear_block();
    foreach (sym_rank[i]) sym_rank[i] = '0;
    // directed: empty emit, single value, extremes, ties
    pending_items.push_back(mk(CMD_EMIT, 8'hFF));
    pending_items.push_back(mk(CMD_LOAD, 8'h00));
    pending_items.push_back(mk(CMD_LOAD, 8'h00));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_LOAD, 8'hFF));
    pending_items.push_back(mk(CMD_LOAD, 8'h00));
    pending_items.push_back(mk(CMD_LOAD, 8'h80));
    pending_items.push_back(mk(CMD_LOAD, 8'hFF));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_LOAD, 8'h55));
    pending_items.push_back(mk(CMD_EMIT, 8'hFF));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    pending_items.push_back(mk(CMD_EMIT, 8'h00));
    // full block with overflow
    for (int i = 0; i < BLK + 2; i++)
      pending_items.push_back(mk(CMD_LOAD, 8'(i)));
    for (int i = 0; i < BLK; i++)
      pending_items.push_back(mk(CMD_EMIT, 8'h00));
    while (pending_items.size() < 900) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(mk(1'($urandom), 8'($urandom)));
        1: add_block($urandom_range(1, 3), 256, 1'b1);
        default: add_block($urandom_range(2, 24), $urandom_range(1, 12),
                           $urandom_range(0, 3) == 0);
      endcase
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_code(req);
        gap = $urandom_range(0, 3);
        if (gap == 0 && pending_items.size() > 0) begin
          req <= pending_items.pop_front();
        end else begin
          req_valid <= 1'b0;
          if (pending_items.size() == 0) stim_done <= 1'b1;
        end
      end else if (!req_valid) begin
        if (gap > 0) gap--;
        else if (pending_items.size() > 0) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else stim_done <= 1'b1;
      end
    end
  end

  // monitor
  int res_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        res_wait = $urandom_range(0, 3);
        if (expected_codes.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin : cmp
          res_t e;
          e = expected_codes.pop_front();
          if (res.out_symbol !== e.out_symbol) begin
            $error("out_symbol exp %0d got %0d", e.out_symbol, res.out_symbol); errors++;
          end
          if (res.rank !== e.rank) begin
            $error("rank exp %0d got %0d", e.rank, res.rank); errors++;
          end
          if (res.code_length !== e.code_length) begin
            $error("code_length exp %0d got %0d", e.code_length, res.code_length); errors++;
          end
          if (res.ends_in_zero !== e.ends_in_zero) begin
            $error("ends_in_zero exp %0b got %0b", e.ends_in_zero, res.ends_in_zero); errors++;
          end
          if (res.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, res.last); errors++;
          end
          if (res.none_left !== e.none_left) begin
            $error("none_left exp %0b got %0b", e.none_left, res.none_left); errors++;
          end
          if (res.overflowed !== e.overflowed) begin
            $error("overflowed exp %0b got %0b", e.overflowed, res.overflowed); errors++;
          end
        end
      end else if (res_valid && res_wait > 0) begin
        res_wait--;
      end
      res_stall <= (res_wait > 0);
    end
  end

  initial begin
    wait (!rst);
    wait (stim_done && !req_valid && expected_codes.size() == 0);
    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
